/* hw/rtl/qau_pkg.sv */
// qau_pkg: shared types, opcodes, pipeline depths and saturation helper
// for the quaternion arithmetic unit; depends on nothing else
`timescale 1ns / 1ps

package qau_pkg;

  localparam int unsigned FRAC_BITS_DEF = 16;
  localparam int unsigned N_LANES       = 4;
  localparam int unsigned N_PROD        = 16;

  // square root: 32 digit steps plus rounding register
  localparam int unsigned SQRT_LAT    = 33;
  // divider: setup register plus 32 quotient steps
  localparam int unsigned DIV_LAT     = 33;
  // accept edge to the edge that takes the result beat
  localparam int unsigned QAU_LATENCY = 4 + SQRT_LAT + DIV_LAT + 1;

  // product slots that are subtracted in the hamilton lane sums
  localparam logic [N_PROD-1:0] HAM_NEG = 16'hE888;

  typedef enum logic [2:0] {
    OP_ADD,
    OP_SCALE,
    OP_MUL,
    OP_NEG,
    OP_NORM,
    OP_INV,
    OP_LEN,
    OP_MAT
  } opcode_e;

  typedef enum logic [1:0] {
    ROW_X,
    ROW_Y,
    ROW_Z,
    ROW_W
  } row_e;

  // per-item control and lane data that travels beside the arithmetic
  typedef struct packed {
    logic                valid;
    opcode_e             op;
    logic                zero;
    logic [3:0]          neg;
    logic [3:0][31:0]    mag;
    logic [3:0][31:0]    res;
  } side_t;

  // clamp a wide signed value to the signed 32-bit range
  function automatic logic [31:0] sat32(input logic signed [67:0] v);
    logic [31:0] r;
    if (v > 68'sd2147483647) begin
      r = 32'h7fff_ffff;
    end else if (v < -68'sd2147483648) begin
      r = 32'h8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

/* hw/rtl/qau_sqrt.sv */
// qau_sqrt: pipelined 64-bit integer square root, rounded to nearest,
// one digit step per stage; uses qau_pkg for the pipeline depth
`timescale 1ns / 1ps

module qau_sqrt (
  input  logic        clk_i,
  input  logic [63:0] n_i,
  output logic [32:0] root_o
);
  import qau_pkg::*;

  localparam int unsigned STEPS = SQRT_LAT - 1;

  logic [63:0] rem_q [1:STEPS];
  logic [63:0] res_q [1:STEPS];
  logic [32:0] root_q;

  // one result bit per stage
  for (genvar k = 0; k < STEPS; k++) begin : g_step
    localparam logic [63:0] BIT = 64'd1 << (62 - 2 * k);
    logic [63:0] n_cur;
    logic [63:0] r_cur;
    logic [63:0] trial;

    if (k == 0) begin : g_first
      assign n_cur = n_i;
      assign r_cur = '0;
    end else begin : g_next
      assign n_cur = rem_q[k];
      assign r_cur = res_q[k];
    end

    assign trial = r_cur + BIT;

    always_ff @(posedge clk_i) begin
      if (n_cur >= trial) begin
        rem_q[k+1] <= n_cur - trial;
        res_q[k+1] <= (r_cur >> 1) + BIT;
      end else begin
        rem_q[k+1] <= n_cur;
        res_q[k+1] <= r_cur >> 1;
      end
    end
  end

  // round to nearest from the final remainder
  always_ff @(posedge clk_i) begin
    root_q <= 33'(res_q[STEPS]) + 33'(rem_q[STEPS] > res_q[STEPS]);
  end

  assign root_o = root_q;

endmodule

/* hw/rtl/qau_div.sv */
// qau_div: pipelined rounding divider, round(m * 2^k / d) for k of
// FRAC_BITS or 2*FRAC_BITS, one quotient bit per stage; uses qau_pkg
`timescale 1ns / 1ps

module qau_div #(
  parameter int unsigned FRAC_BITS = qau_pkg::FRAC_BITS_DEF
) (
  input  logic        clk_i,
  input  logic [31:0] m_i,
  input  logic [63:0] d_i,
  input  logic        inv_i,
  output logic [32:0] q_o
);
  import qau_pkg::*;

  localparam int unsigned QB = DIV_LAT - 1;
  localparam int unsigned NW = ((2 * FRAC_BITS + 33) > 64 ? 2 * FRAC_BITS + 33 : 64) + 1;

  logic [NW-1:0] n0;
  logic [64:0]   d2;
  logic          ovf0;

  logic [NW-1:0] r_q   [QB+1];
  logic [64:0]   d_q   [QB+1];
  logic [QB-1:0] q_q   [QB+1];
  logic          ovf_q [QB+1];

  // numerator 2*m*2^k + d over divisor 2*d gives round half up
  always_comb begin
    if (inv_i) begin
      n0 = (NW'(m_i) << (2 * FRAC_BITS + 1)) + NW'(d_i);
    end else begin
      n0 = (NW'(m_i) << (FRAC_BITS + 1)) + NW'(d_i);
    end
    d2   = {d_i, 1'b0};
    ovf0 = (n0 >> QB) >= NW'(d2);
  end

  always_ff @(posedge clk_i) begin
    r_q[0]   <= n0;
    d_q[0]   <= d2;
    q_q[0]   <= '0;
    ovf_q[0] <= ovf0;
  end

  // restoring steps, most significant quotient bit first
  for (genvar k = 0; k < QB; k++) begin : g_step
    localparam int unsigned SH = QB - 1 - k;
    logic fits;

    assign fits = (r_q[k] >> SH) >= NW'(d_q[k]);

    always_ff @(posedge clk_i) begin
      r_q[k+1]   <= fits ? r_q[k] - (NW'(d_q[k]) << SH) : r_q[k];
      d_q[k+1]   <= d_q[k];
      q_q[k+1]   <= q_q[k] | (QB'(fits) << SH);
      ovf_q[k+1] <= ovf_q[k];
    end
  end

  // an overflowing quotient reads as all ones, which saturates later
  assign q_o = ovf_q[QB] ? '1 : {1'b0, q_q[QB]};

endmodule

/* hw/rtl/quaternion_arithmetic_unit.sv */
// quaternion_arithmetic_unit: Q-format quaternion ALU, top level; uses
// qau_pkg, qau_sqrt and qau_div. Each item passes the front stages, the
// 32-step root pipeline, the 32-step divider and the output register.
// Throughput: one item per cycle, busy stays low. Reset clears all valid
// bits, nothing is in flight.
`timescale 1ns / 1ps

module quaternion_arithmetic_unit #(
  parameter int unsigned FRAC_BITS = qau_pkg::FRAC_BITS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic [2:0]         opcode_i,
  input  logic [1:0]         row_index_i,
  input  logic signed [31:0] a_x_i,
  input  logic signed [31:0] a_y_i,
  input  logic signed [31:0] a_z_i,
  input  logic signed [31:0] a_w_i,
  input  logic signed [31:0] b_x_i,
  input  logic signed [31:0] b_y_i,
  input  logic signed [31:0] b_z_i,
  input  logic signed [31:0] b_w_i,
  input  logic signed [31:0] scale_factor_i,
  output logic               result_valid_o,
  output logic signed [31:0] res_x_o,
  output logic signed [31:0] res_y_o,
  output logic signed [31:0] res_z_o,
  output logic signed [31:0] res_w_o,
  output logic               zero_length_o
);
  import qau_pkg::*;

  localparam logic signed [64:0] HALF = 65'sd1 <<< (FRAC_BITS - 1);
  localparam logic signed [67:0] ONE  = 68'sd1 <<< FRAC_BITS;

  logic signed [31:0] av [N_LANES];
  logic signed [31:0] bv [N_LANES];
  opcode_e            op_in;

  // stage 1: operand select
  side_t              s1_d, s1_q;
  row_e               row1_q;
  logic signed [31:0] x_d  [N_PROD];
  logic signed [31:0] y_d  [N_PROD];
  logic signed [31:0] x1_q [N_PROD];
  logic signed [31:0] y1_q [N_PROD];

  // stage 2: products
  side_t              s2_q;
  row_e               row2_q;
  logic signed [63:0] p2_q [N_PROD];

  // stage 3: rounded products and squared length
  side_t              s3_q;
  row_e               row3_q;
  logic signed [64:0] rnd_t [N_PROD];
  logic signed [63:0] rp3_q [N_PROD];
  logic [64:0]        sq_sum;
  logic [63:0]        sq3_q;

  // stage 4: lane sums
  side_t              s4_d, s4_q;
  logic [63:0]        sq4_q;
  logic signed [67:0] ham_sum [N_LANES];
  logic signed [67:0] mat_row [N_LANES];
  logic signed [67:0] m_xy, m_xz, m_yz, m_xx, m_yy, m_zz, m_wx, m_wy, m_wz;

  // root and divider section
  side_t              sl1_q [SQRT_LAT];
  logic [63:0]        sqs_q [SQRT_LAT];
  logic [32:0]        root;
  side_t              mid;
  logic [63:0]        div_d;
  logic               div_inv;
  logic [32:0]        q_div [N_LANES];
  side_t              sl2_q [DIV_LAT];

  // output register
  side_t              tail;
  logic [31:0]        lane   [N_LANES];
  logic [31:0]        out_d  [N_LANES];
  logic [31:0]        out_q  [N_LANES];
  logic               valid_q;
  logic               zero_q;

  // the pipeline never holds off an item
  assign busy = 1'b0;

  assign av[0] = a_x_i;
  assign av[1] = a_y_i;
  assign av[2] = a_z_i;
  assign av[3] = a_w_i;
  assign bv[0] = b_x_i;
  assign bv[1] = b_y_i;
  assign bv[2] = b_z_i;
  assign bv[3] = b_w_i;
  assign op_in = opcode_e'(opcode_i);

  // route operands to the shared multipliers, direct results for add and negate
  always_comb begin
    s1_d       = '0;
    s1_d.valid = start & ~busy;
    s1_d.op    = op_in;
    for (int i = 0; i < N_PROD; i++) begin
      x_d[i] = '0;
      y_d[i] = '0;
    end
    for (int i = 0; i < N_LANES; i++) begin
      s1_d.mag[i] = av[i][31] ? 32'(-av[i]) : 32'(av[i]);
      if (op_in == OP_INV && i < 3) begin
        s1_d.neg[i] = ~av[i][31] & (av[i] != '0);
      end else begin
        s1_d.neg[i] = av[i][31];
      end
    end
    unique case (op_in) inside
      OP_ADD: begin
        for (int i = 0; i < N_LANES; i++) begin
          s1_d.res[i] = sat32(68'(av[i]) + 68'(bv[i]));
        end
      end
      OP_NEG: begin
        for (int i = 0; i < N_LANES; i++) begin
          s1_d.res[i] = sat32(-68'(av[i]));
        end
      end
      OP_SCALE: begin
        for (int i = 0; i < N_LANES; i++) begin
          x_d[4*i] = av[i];
          y_d[4*i] = scale_factor_i;
        end
      end
      OP_MUL: begin
        x_d[0]  = av[3]; y_d[0]  = bv[0];
        x_d[1]  = bv[3]; y_d[1]  = av[0];
        x_d[2]  = av[1]; y_d[2]  = bv[2];
        x_d[3]  = av[2]; y_d[3]  = bv[1];
        x_d[4]  = av[3]; y_d[4]  = bv[1];
        x_d[5]  = bv[3]; y_d[5]  = av[1];
        x_d[6]  = av[2]; y_d[6]  = bv[0];
        x_d[7]  = av[0]; y_d[7]  = bv[2];
        x_d[8]  = av[3]; y_d[8]  = bv[2];
        x_d[9]  = bv[3]; y_d[9]  = av[2];
        x_d[10] = av[0]; y_d[10] = bv[1];
        x_d[11] = av[1]; y_d[11] = bv[0];
        x_d[12] = av[3]; y_d[12] = bv[3];
        x_d[13] = av[0]; y_d[13] = bv[0];
        x_d[14] = av[1]; y_d[14] = bv[1];
        x_d[15] = av[2]; y_d[15] = bv[2];
      end
      OP_NORM, OP_INV, OP_LEN: begin
        for (int i = 0; i < N_LANES; i++) begin
          x_d[i] = av[i];
          y_d[i] = av[i];
        end
      end
      OP_MAT: begin
        x_d[0] = av[0]; y_d[0] = av[1];
        x_d[1] = av[0]; y_d[1] = av[2];
        x_d[2] = av[1]; y_d[2] = av[2];
        x_d[3] = av[0]; y_d[3] = av[0];
        x_d[4] = av[1]; y_d[4] = av[1];
        x_d[5] = av[2]; y_d[5] = av[2];
        x_d[6] = av[3]; y_d[6] = av[0];
        x_d[7] = av[3]; y_d[7] = av[1];
        x_d[8] = av[3]; y_d[8] = av[2];
      end
    endcase
  end

  // front pipeline valid and control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q <= '0;
      s2_q <= '0;
      s3_q <= '0;
      s4_q <= '0;
    end else begin
      s1_q <= s1_d;
      s2_q <= s1_q;
      s3_q <= s2_q;
      s4_q <= s4_d;
    end
  end

  // front pipeline payload
  always_ff @(posedge clk_i) begin
    row1_q <= row_e'(row_index_i);
    row2_q <= row1_q;
    row3_q <= row2_q;
    for (int i = 0; i < N_PROD; i++) begin
      x1_q[i]  <= x_d[i];
      y1_q[i]  <= y_d[i];
      p2_q[i]  <= x1_q[i] * y1_q[i];
      rp3_q[i] <= 64'(rnd_t[i] >>> FRAC_BITS);
    end
    sq3_q <= sq_sum[64] ? '1 : sq_sum[63:0];
    sq4_q <= sq3_q;
  end

  // product rounding and exact squared length
  always_comb begin
    for (int i = 0; i < N_PROD; i++) begin
      rnd_t[i] = 65'(p2_q[i]) + HALF;
    end
    sq_sum = {1'b0, p2_q[0]} + {1'b0, p2_q[1]} + {1'b0, p2_q[2]} + {1'b0, p2_q[3]};
  end

  assign m_xy = 68'(rp3_q[0]);
  assign m_xz = 68'(rp3_q[1]);
  assign m_yz = 68'(rp3_q[2]);
  assign m_xx = 68'(rp3_q[3]);
  assign m_yy = 68'(rp3_q[4]);
  assign m_zz = 68'(rp3_q[5]);
  assign m_wx = 68'(rp3_q[6]);
  assign m_wy = 68'(rp3_q[7]);
  assign m_wz = 68'(rp3_q[8]);

  // hamilton and scale lanes share one signed sum per lane
  always_comb begin
    for (int j = 0; j < N_LANES; j++) begin
      ham_sum[j] = '0;
      for (int k = 0; k < 4; k++) begin
        if (HAM_NEG[4*j+k]) begin
          ham_sum[j] = ham_sum[j] - 68'(rp3_q[4*j+k]);
        end else begin
          ham_sum[j] = ham_sum[j] + 68'(rp3_q[4*j+k]);
        end
      end
    end
  end

  // rotation matrix row
  always_comb begin
    for (int j = 0; j < N_LANES; j++) begin
      mat_row[j] = '0;
    end
    unique case (row3_q)
      ROW_X: begin
        mat_row[0] = ONE - ((m_yy + m_zz) <<< 1);
        mat_row[1] = (m_xy + m_wz) <<< 1;
        mat_row[2] = (m_xz - m_wy) <<< 1;
      end
      ROW_Y: begin
        mat_row[0] = (m_xy - m_wz) <<< 1;
        mat_row[1] = ONE - ((m_xx + m_zz) <<< 1);
        mat_row[2] = (m_yz + m_wx) <<< 1;
      end
      ROW_Z: begin
        mat_row[0] = (m_xz + m_wy) <<< 1;
        mat_row[1] = (m_yz - m_wx) <<< 1;
        mat_row[2] = ONE - ((m_xx + m_yy) <<< 1);
      end
      ROW_W: begin
        mat_row[3] = ONE;
      end
    endcase
  end

  // stage 4 lane results and zero length detect
  always_comb begin
    s4_d      = s3_q;
    s4_d.zero = (s3_q.op == OP_NORM || s3_q.op == OP_INV) && (sq3_q == '0);
    unique case (s3_q.op) inside
      OP_SCALE, OP_MUL: begin
        for (int j = 0; j < N_LANES; j++) begin
          s4_d.res[j] = sat32(ham_sum[j]);
        end
      end
      OP_MAT: begin
        for (int j = 0; j < N_LANES; j++) begin
          s4_d.res[j] = sat32(mat_row[j]);
        end
      end
      OP_ADD, OP_NEG: begin
        s4_d.res = s3_q.res;
      end
      OP_NORM, OP_INV, OP_LEN: begin
        s4_d.res = '0;
      end
    endcase
  end

  // length of A
  qau_sqrt u_sqrt (
    .clk_i  (clk_i),
    .n_i    (sq4_q),
    .root_o (root)
  );

  // side data beside the root pipeline
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < SQRT_LAT; k++) begin
        sl1_q[k] <= '0;
      end
    end else begin
      sl1_q[0] <= s4_q;
      for (int k = 1; k < SQRT_LAT; k++) begin
        sl1_q[k] <= sl1_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    sqs_q[0] <= sq4_q;
    for (int k = 1; k < SQRT_LAT; k++) begin
      sqs_q[k] <= sqs_q[k-1];
    end
  end

  // length result and divisor choice
  always_comb begin
    mid = sl1_q[SQRT_LAT-1];
    if (mid.op == OP_LEN) begin
      mid.res[3] = (root > 33'h0_7fff_ffff) ? 32'h7fff_ffff : root[31:0];
    end
    div_inv = (mid.op == OP_INV);
    div_d   = div_inv ? sqs_q[SQRT_LAT-1] : 64'(root);
  end

  for (genvar i = 0; i < N_LANES; i++) begin : g_div
    qau_div #(
      .FRAC_BITS (FRAC_BITS)
    ) u_div (
      .clk_i (clk_i),
      .m_i   (mid.mag[i]),
      .d_i   (div_d),
      .inv_i (div_inv),
      .q_o   (q_div[i])
    );
  end

  // side data beside the divider
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < DIV_LAT; k++) begin
        sl2_q[k] <= '0;
      end
    end else begin
      sl2_q[0] <= mid;
      for (int k = 1; k < DIV_LAT; k++) begin
        sl2_q[k] <= sl2_q[k-1];
      end
    end
  end

  // signed, saturated quotients and final select
  always_comb begin
    tail = sl2_q[DIV_LAT-1];
    for (int i = 0; i < N_LANES; i++) begin
      if (tail.neg[i]) begin
        lane[i] = (q_div[i] > 33'h0_8000_0000) ? 32'h8000_0000 : 32'(-q_div[i]);
      end else begin
        lane[i] = (q_div[i] > 33'h0_7fff_ffff) ? 32'h7fff_ffff : q_div[i][31:0];
      end
      if (tail.op == OP_NORM || tail.op == OP_INV) begin
        out_d[i] = tail.zero ? '0 : lane[i];
      end else begin
        out_d[i] = tail.res[i];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      zero_q  <= 1'b0;
    end else begin
      valid_q <= tail.valid;
      zero_q  <= tail.valid & tail.zero;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < N_LANES; i++) begin
      out_q[i] <= out_d[i];
    end
  end

  assign result_valid_o = valid_q;
  assign zero_length_o  = zero_q;
  assign res_x_o        = out_q[0];
  assign res_y_o        = out_q[1];
  assign res_z_o        = out_q[2];
  assign res_w_o        = out_q[3];

endmodule

/* hw/rtl/qau_checker.sv */
// qau_checker: port-level checks on the quaternion arithmetic unit,
// bound to the top level; uses qau_pkg for the fixed latency
`timescale 1ns / 1ps

module qau_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               start,
  input logic               busy,
  input logic               result_valid_o,
  input logic signed [31:0] res_x_o,
  input logic signed [31:0] res_y_o,
  input logic signed [31:0] res_z_o,
  input logic signed [31:0] res_w_o,
  input logic               zero_length_o
);
  import qau_pkg::*;

  localparam int unsigned CW = $clog2(QAU_LATENCY + 2);

  logic [CW-1:0] since_rst_q;

  // edges since reset, held once the pipeline has filled
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      since_rst_q <= '0;
    end else if (since_rst_q != CW'(QAU_LATENCY + 1)) begin
      since_rst_q <= since_rst_q + 1'b1;
    end
  end

  // the unit never holds off a beat
  assert property (@(posedge clk_i) disable iff (!rst_ni) !busy)
    else $error("busy raised");

  // every accepted beat comes back after the fixed latency, and nothing else
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (since_rst_q == CW'(QAU_LATENCY + 1)) |->
      (result_valid_o == $past(start && !busy, QAU_LATENCY)))
    else $error("result beat out of step with accepted beats");

  // zero length flag only on a result beat
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    zero_length_o |-> result_valid_o)
    else $error("zero length flag without result beat");

  // zero length gives an all-zero quaternion
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    zero_length_o |-> (res_x_o == '0 && res_y_o == '0 && res_z_o == '0 && res_w_o == '0))
    else $error("zero length result not cleared");

endmodule

bind quaternion_arithmetic_unit qau_checker u_qau_checker (.*);
